FILE: design/sms_pkg.sv
// shared types, codes and default sizes for the shared-pool multi-stack
package sms_pkg;

  localparam int POOL_DEPTH_DEF = 256;
  localparam int NUM_STACKS_DEF = 8;
  localparam int DATA_W         = 32;
  localparam int SID_IN_W       = 3;
  localparam int STATUS_W       = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam logic    REQ_PUSH  = 1'b0;
  localparam logic    REQ_POP   = 1'b1;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_EMPTY  = 2'd2;

endpackage

FILE: design/sms_pool_mem.sv
// pool entry memory holding link and data word, with fill count for unwritten links
module sms_pool_mem
  import sms_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int IDX_W      = $clog2(POOL_DEPTH),
  parameter int PTR_W      = $clog2(POOL_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [PTR_W-1:0]  rd_link,
  output logic [DATA_W-1:0] rd_elem,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [PTR_W-1:0]  wr_link,
  input  logic [DATA_W-1:0] wr_elem
);

  localparam int ENT_W = PTR_W + DATA_W;

  logic [ENT_W-1:0] mem [POOL_DEPTH];
  logic [ENT_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr_q;
  logic             fresh_q;
  logic [PTR_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_link, wr_elem};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      fresh_q   <= PTR_W'(rd_addr) >= fill;
    end
  end

  // entries are first taken in index order, so those below fill hold written links
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr_en && PTR_W'(wr_addr) == fill) begin
      fill <= fill + PTR_W'(1);
    end
  end

  assign rd_link = fresh_q ? PTR_W'(rd_addr_q) + PTR_W'(1) : rd_q[ENT_W-1:DATA_W];
  assign rd_elem = rd_q[DATA_W-1:0];

endmodule

FILE: design/sms_tops_mem.sv
// stack top pointer memory with per-stack valid bits
module sms_tops_mem
  import sms_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int SID_W      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1,
  parameter int PTR_W      = $clog2(POOL_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [SID_W-1:0] rd_addr,
  output logic [PTR_W-1:0] rd_top,
  input  logic             wr_en,
  input  logic [SID_W-1:0] wr_addr,
  input  logic [PTR_W-1:0] wr_top
);

  logic [PTR_W-1:0]      mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] written;
  logic [PTR_W-1:0]      rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_top;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // a stack never written is empty
  assign rd_top = rd_vld_q ? rd_q : PTR_W'(POOL_DEPTH);

endmodule

FILE: design/shared_pool_multi_stack.sv
// top level: several lifo stacks linked through one shared entry pool
// sequence: an accepted request goes to S_LOOK, where a push or a refused pop sets
// its result strobe; a granted pop goes on to S_FETCH first; busy stays high until the result is set
// requests are taken one at a time: a new start is accepted only when idle, after the
// chained top-pointer read and pool read in the synchronous memories are through
// reset: synchronous; pool and tops need no clearing pass, ready at once
module shared_pool_multi_stack
  import sms_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int NUM_STACKS = NUM_STACKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                req_type,
  input  logic [SID_IN_W-1:0] stack_id,
  input  logic [DATA_W-1:0]   value,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [DATA_W-1:0]   pop_value
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int PTR_W = $clog2(POOL_DEPTH + 1);
  localparam int SID_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(POOL_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic              req_q;
  logic [SID_W-1:0]  sid_q;
  logic              in_range_q;
  logic [DATA_W-1:0] value_q;
  logic [PTR_W-1:0]  top_q;
  logic [PTR_W-1:0]  free_head;

  logic [8:0]        sid_wide;
  logic              accept;
  logic [PTR_W-1:0]  top_ptr;
  logic              push_go;
  logic              pop_go;

  logic              pool_rd_en;
  logic [IDX_W-1:0]  pool_rd_addr;
  logic [PTR_W-1:0]  pool_rd_link;
  logic [DATA_W-1:0] pool_rd_elem;
  logic              pool_wr_en;
  logic [IDX_W-1:0]  pool_wr_addr;
  logic [PTR_W-1:0]  pool_wr_link;
  logic [DATA_W-1:0] pool_wr_elem;
  logic              tops_wr_en;
  logic [PTR_W-1:0]  tops_wr_top;

  assign sid_wide = 9'(stack_id);
  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);

  assign push_go = (state == S_LOOK) && (req_q == REQ_PUSH) && in_range_q
                   && (free_head < PTR_NULL);
  assign pop_go  = (state == S_LOOK) && (req_q == REQ_POP) && in_range_q
                   && (top_ptr < PTR_NULL);

  assign pool_rd_en   = accept || pop_go;
  assign pool_rd_addr = (state == S_IDLE) ? free_head[IDX_W-1:0] : top_ptr[IDX_W-1:0];
  assign pool_wr_en   = push_go || (state == S_FETCH);
  assign pool_wr_addr = (state == S_FETCH) ? top_q[IDX_W-1:0] : free_head[IDX_W-1:0];
  assign pool_wr_link = (state == S_FETCH) ? free_head : top_ptr;
  assign pool_wr_elem = (state == S_FETCH) ? pool_rd_elem : value_q;
  assign tops_wr_en   = push_go || (state == S_FETCH);
  assign tops_wr_top  = (state == S_FETCH) ? pool_rd_link : free_head;

  sms_pool_mem #(
    .POOL_DEPTH (POOL_DEPTH),
    .IDX_W      (IDX_W),
    .PTR_W      (PTR_W)
  ) u_pool (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (pool_rd_en),
    .rd_addr (pool_rd_addr),
    .rd_link (pool_rd_link),
    .rd_elem (pool_rd_elem),
    .wr_en   (pool_wr_en),
    .wr_addr (pool_wr_addr),
    .wr_link (pool_wr_link),
    .wr_elem (pool_wr_elem)
  );

  sms_tops_mem #(
    .POOL_DEPTH (POOL_DEPTH),
    .NUM_STACKS (NUM_STACKS),
    .SID_W      (SID_W),
    .PTR_W      (PTR_W)
  ) u_tops (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (sid_wide[SID_W-1:0]),
    .rd_top  (top_ptr),
    .wr_en   (tops_wr_en),
    .wr_addr (sid_q),
    .wr_top  (tops_wr_top)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = pop_go ? S_FETCH : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (push_go) begin
        free_head <= pool_rd_link;
      end else if (state == S_FETCH) begin
        free_head <= top_q;
      end
      if ((state == S_LOOK && !pop_go) || state == S_FETCH) begin
        done <= 1'b1;
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q      <= req_type;
      sid_q      <= sid_wide[SID_W-1:0];
      in_range_q <= sid_wide < 9'(NUM_STACKS);
      value_q    <= value;
    end
    if (pop_go) begin
      top_q <= top_ptr;
    end
    if (state == S_LOOK && !pop_go) begin
      pop_value <= '0;
      if (push_go) begin
        status <= ST_OK;
      end else if (req_q == REQ_PUSH) begin
        status <= ST_FULL;
      end else begin
        status <= ST_EMPTY;
      end
    end else if (state == S_FETCH) begin
      status    <= ST_OK;
      pop_value <= pool_rd_elem;
    end
  end

endmodule

FILE: design/sms_checker.sv
// port-level checks for the shared-pool multi-stack, bound to the top level
module sms_checker
  import sms_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                req_type,
  input logic                done,
  input logic [STATUS_W-1:0] status,
  input logic [DATA_W-1:0]   pop_value
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_push_two: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == REQ_PUSH |-> ##2 done)
    else $error("push result not delivered two cycles after accept");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == ST_OK || status == ST_FULL || status == ST_EMPTY)
    else $error("undefined status code");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> pop_value == '0)
    else $error("refused request gave non-zero pop value");

endmodule

bind shared_pool_multi_stack sms_checker u_sms_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .req_type  (req_type),
  .done      (done),
  .status    (status),
  .pop_value (pop_value)
);
